// ===== rtl/umpc_pkg.sv =====
// Shared types, constants and helpers for the unicycle MPC residual/cost unit.
// Depends on nothing; used by the controller, the datapath and the top level.
package umpc_pkg;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_REM,
    S_ZINIT,
    S_CORDIC,
    S_ROT,
    S_MULT,
    S_RES
  } umpc_state_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP_TIME = 2'd0;
  localparam logic [1:0] CFG_POS_W     = 2'd1;
  localparam logic [1:0] CFG_MOTION_W  = 2'd2;
  localparam logic [1:0] CFG_EFFORT_W  = 2'd3;

  // Quarter-turn codes
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam int          CORDIC_STEPS = 16;
  localparam int          COST_TERMS   = 6;
  localparam int          STATE_TERMS  = 4;
  localparam logic signed [31:0] TURN_PER_RAD = 32'sd683565276;
  localparam logic signed [31:0] RAD_PER_TURN = 32'sd411775;
  localparam logic signed [19:0] CORDIC_START = 20'sd39797;
  localparam logic [47:0] COST_MAX = 48'hFFFF_FFFF_FFFF;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       phase;
    logic       rem;
    logic       zinit;
    logic       rotate;
    logic [3:0] iter;
    logic       term_issue;
    logic       fin;
    logic       mult;
    logic       commit;
  } umpc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;
    logic out_free;
  } umpc_status_t;

  // Arctangent of 2^-i in Q16 radians
  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] r;
    case (i)
      4'd0:    r = 16'd51472;
      4'd1:    r = 16'd30386;
      4'd2:    r = 16'd16055;
      4'd3:    r = 16'd8150;
      4'd4:    r = 16'd4091;
      4'd5:    r = 16'd2047;
      4'd6:    r = 16'd1024;
      4'd7:    r = 16'd512;
      4'd8:    r = 16'd256;
      4'd9:    r = 16'd128;
      4'd10:   r = 16'd64;
      4'd11:   r = 16'd32;
      4'd12:   r = 16'd16;
      4'd13:   r = 16'd8;
      4'd14:   r = 16'd4;
      4'd15:   r = 16'd2;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647)
      r = 32'sh7FFF_FFFF;
    else if (v < -40'sd2147483648)
      r = 32'sh8000_0000;
    else
      r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/umpc_ctrl.sv =====
// Sequencer for the unicycle MPC residual/cost unit.
// Depends on umpc_pkg; drives umpc_cmd_t to the datapath, reads umpc_status_t.
module umpc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  umpc_pkg::umpc_status_t status,
  output umpc_pkg::umpc_cmd_t   cmd
);
  import umpc_pkg::*;

  umpc_state_t state, state_next;
  logic [3:0]  iter, iter_next;

  // State and iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    iter_next  = '0;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_PHASE;
      S_PHASE:  state_next = S_REM;
      S_REM:    state_next = S_ZINIT;
      S_ZINIT:  state_next = S_CORDIC;
      S_CORDIC: begin
        iter_next = iter + 4'd1;
        if (iter == 4'(CORDIC_STEPS - 1)) state_next = S_ROT;
      end
      S_ROT:    state_next = S_MULT;
      S_MULT:   state_next = S_RES;
      S_RES:    if (status.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    cmd.iter   = iter;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_PHASE:  cmd.phase = 1'b1;
      S_REM:    cmd.rem   = 1'b1;
      S_ZINIT:  cmd.zinit = 1'b1;
      S_CORDIC: begin
        cmd.rotate     = 1'b1;
        cmd.term_issue = (iter < 4'(COST_TERMS)) &&
                         ((iter < 4'(STATE_TERMS)) || !status.last);
      end
      S_ROT:    cmd.fin    = 1'b1;
      S_MULT:   cmd.mult   = 1'b1;
      S_RES:    cmd.commit = status.out_free;
      default:  cmd = '0;
    endcase
  end

  // Sequencing checks
  a_cordic_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORDIC && iter == 4'(CORDIC_STEPS - 1)) |=> state == S_ROT)
    else $error("CORDIC did not hand over after its last step");
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == S_IDLE && in_ready))
    else $error("commit not followed by idle");
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (!in_ready && state == S_PHASE))
    else $error("accepted transaction did not start work");
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !in_valid) |=> state == S_IDLE)
    else $error("left idle without a transaction");

endmodule

// ===== rtl/umpc_dp.sv =====
// Datapath of the unicycle MPC residual/cost unit: CORDIC, prediction, cost pipe.
// Depends on umpc_pkg; commanded by umpc_ctrl.
module umpc_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  umpc_pkg::umpc_cmd_t    cmd,
  output umpc_pkg::umpc_status_t status,
  input  logic                   cfg_write_en,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic signed [31:0]     pos_x,
  input  logic signed [31:0]     pos_y,
  input  logic signed [31:0]     heading,
  input  logic signed [31:0]     speed,
  input  logic signed [31:0]     yaw_rate,
  input  logic signed [31:0]     accel,
  input  logic signed [31:0]     yaw_accel,
  input  logic signed [31:0]     ref_x,
  input  logic signed [31:0]     ref_y,
  input  logic signed [31:0]     ref_heading,
  input  logic signed [31:0]     ref_speed,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     residual_x,
  output logic signed [31:0]     residual_y,
  output logic signed [31:0]     residual_heading,
  output logic signed [31:0]     residual_speed,
  output logic signed [31:0]     residual_yaw_rate,
  output logic [47:0]            cost_total,
  output logic                   cost_final
);
  import umpc_pkg::*;

  // Configuration
  logic [15:0] step_time;
  logic [7:0]  position_weight, motion_weight, effort_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time       <= 16'd6554;
      position_weight <= 8'd10;
      motion_weight   <= 8'd1;
      effort_weight   <= 8'd1;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_STEP_TIME: step_time       <= cfg_data;
        CFG_POS_W:     position_weight <= cfg_data[7:0];
        CFG_MOTION_W:  motion_weight   <= cfg_data[7:0];
        CFG_EFFORT_W:  effort_weight   <= cfg_data[7:0];
        default:       step_time       <= step_time;
      endcase
    end
  end

  // Latched transaction
  logic signed [31:0] st_x, st_y, st_h, st_v, st_w, ctl_a, ctl_wd;
  logic signed [31:0] rf_x, rf_y, rf_h, rf_v;
  logic               item_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_x <= pos_x;   st_y <= pos_y;  st_h <= heading; st_v <= speed;
      st_w <= yaw_rate; ctl_a <= accel; ctl_wd <= yaw_accel;
      rf_x <= ref_x;   rf_y <= ref_y;  rf_h <= ref_heading; rf_v <= ref_speed;
      item_last <= last;
    end
  end

  // Previous step and horizon start flag
  logic signed [31:0] pv_x, pv_y, pv_h, pv_v, pv_w, pv_a, pv_wd;
  logic               at_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv_x <= '0; pv_y <= '0; pv_h <= '0; pv_v <= '0; pv_w <= '0;
      pv_a <= '0; pv_wd <= '0;
      at_start <= 1'b1;
    end else if (cmd.commit) begin
      pv_x <= st_x; pv_y <= st_y; pv_h <= st_h; pv_v <= st_v; pv_w <= st_w;
      pv_a <= ctl_a; pv_wd <= ctl_wd;
      at_start <= item_last;
    end
  end

  // Angle reduction: heading to turn fraction, then quarter and remainder
  logic signed [63:0] ph_full;
  logic [31:0]        phase;
  logic [31:0]        dtsq;
  logic [31:0]        ph_rnd;
  logic [1:0]         quad;
  logic signed [31:0] rem;
  logic signed [51:0] zp;
  logic [15:0]        hdt2;

  assign ph_full = pv_h * TURN_PER_RAD;
  assign ph_rnd  = phase + 32'h2000_0000;
  assign rem     = $signed(phase - {ph_rnd[31:30], 30'd0});

  always_ff @(posedge clk) begin
    if (cmd.phase) begin
      phase <= ph_full[47:16];
      dtsq  <= 32'(step_time) * 32'(step_time);
    end
    if (cmd.rem) begin
      quad <= ph_rnd[31:30];
      zp   <= 52'(rem) * 52'(RAD_PER_TURN);
      hdt2 <= 16'((33'(dtsq) + 33'd65536) >> 17);
    end
  end

  // Motion products
  logic signed [48:0] p_vdt, p_ah, p_wdt, p_wdh, p_adt, p_wddt;
  logic signed [16:0] dt_s, hdt2_s;

  assign dt_s   = $signed({1'b0, step_time});
  assign hdt2_s = $signed({1'b0, hdt2});

  always_ff @(posedge clk) begin
    if (cmd.zinit) begin
      p_vdt  <= 49'(pv_v)  * 49'(dt_s);
      p_ah   <= 49'(pv_a)  * 49'(hdt2_s);
      p_wdt  <= 49'(pv_w)  * 49'(dt_s);
      p_wdh  <= 49'(pv_wd) * 49'(hdt2_s);
      p_adt  <= 49'(pv_a)  * 49'(dt_s);
      p_wddt <= 49'(pv_wd) * 49'(dt_s);
    end
  end

  // CORDIC rotation, one step per cycle
  logic signed [19:0] cx, cy, cz, dx, dy, at;
  logic signed [51:0] z_rnd;

  assign z_rnd = zp + 52'sd2147483648;
  assign dx    = cy >>> cmd.iter;
  assign dy    = cx >>> cmd.iter;
  assign at    = $signed({4'd0, atan_q16(cmd.iter)});

  always_ff @(posedge clk) begin
    if (cmd.zinit) begin
      cx <= CORDIC_START;
      cy <= '0;
      cz <= 20'(z_rnd >>> 32);
    end else if (cmd.rotate) begin
      if (!cz[19]) begin
        cx <= cx - dx; cy <= cy + dy; cz <= cz - at;
      end else begin
        cx <= cx + dx; cy <= cy - dy; cz <= cz + at;
      end
    end
  end

  // Quarter turn, travel distance and simple increments
  logic signed [19:0] cs_c, cs_s;
  logic signed [49:0] travel_sum, hd_sum;
  logic signed [33:0] travel, hdelta;
  logic signed [32:0] vdelta, wdelta;

  assign travel_sum = 50'(p_vdt) + 50'(p_ah) + 50'sd32768;
  assign hd_sum     = 50'(p_wdt) + 50'(p_wdh) + 50'sd32768;

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      case (quad)
        QUAD_0:  begin cs_c <= cx;  cs_s <= cy;  end
        QUAD_1:  begin cs_c <= -cy; cs_s <= cx;  end
        QUAD_2:  begin cs_c <= -cx; cs_s <= -cy; end
        default: begin cs_c <= cy;  cs_s <= -cx; end
      endcase
      travel <= 34'(travel_sum >>> 16);
      hdelta <= 34'(hd_sum >>> 16);
      vdelta <= 33'((p_adt + 49'sd32768) >>> 16);
      wdelta <= 33'((p_wddt + 49'sd32768) >>> 16);
    end
  end

  // Displacement products
  logic signed [53:0] px, py;

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      px <= 54'(travel) * 54'(cs_c);
      py <= 54'(travel) * 54'(cs_s);
    end
  end

  // Residuals
  logic signed [39:0] rx_full, ry_full, rh_full, rv_full, rw_full;
  logic signed [37:0] dxr, dyr;

  assign dxr     = 38'((px + 54'sd32768) >>> 16);
  assign dyr     = 38'((py + 54'sd32768) >>> 16);
  assign rx_full = 40'(st_x) - (40'(pv_x) + 40'(dxr));
  assign ry_full = 40'(st_y) - (40'(pv_y) + 40'(dyr));
  assign rh_full = 40'(st_h) - (40'(pv_h) + 40'(hdelta));
  assign rv_full = 40'(st_v) - (40'(pv_v) + 40'(vdelta));
  assign rw_full = 40'(st_w) - (40'(pv_w) + 40'(wdelta));

  // Cost pipeline: select, partial squares, round, weight, accumulate
  logic signed [32:0] e_sel;
  logic [7:0]         w_sel;
  logic [32:0]        ca_m;
  logic [7:0]         ca_w, cb_w, cc_w;
  logic               ca_v, cb_v, cc_v, cd_v;
  logic [33:0]        cb_hh;
  logic [32:0]        cb_hl;
  logic [31:0]        cb_ll;
  logic [48:0]        cc_sq;
  logic [56:0]        cd_term;
  logic [64:0]        sq_full;
  logic [47:0]        term_sat;
  logic [48:0]        acc_sum;
  logic [47:0]        cost_acc;

  always_comb begin
    case (cmd.iter[2:0])
      3'd0:    begin e_sel = 33'(st_x) - 33'(rf_x); w_sel = position_weight; end
      3'd1:    begin e_sel = 33'(st_y) - 33'(rf_y); w_sel = position_weight; end
      3'd2:    begin e_sel = 33'(st_h) - 33'(rf_h); w_sel = motion_weight;   end
      3'd3:    begin e_sel = 33'(st_v) - 33'(rf_v); w_sel = motion_weight;   end
      3'd4:    begin e_sel = 33'(ctl_a);             w_sel = effort_weight;   end
      default: begin e_sel = 33'(ctl_wd);            w_sel = effort_weight;   end
    endcase
  end

  assign sq_full  = (65'(cb_hh) << 32) + (65'(cb_hl) << 17) + 65'(cb_ll) + 65'd32768;
  assign term_sat = (cd_term > 57'(COST_MAX)) ? COST_MAX : cd_term[47:0];
  assign acc_sum  = 49'(cost_acc) + 49'(term_sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      ca_v <= 1'b0; cb_v <= 1'b0; cc_v <= 1'b0; cd_v <= 1'b0;
    end else begin
      ca_v <= cmd.term_issue;
      cb_v <= ca_v;
      cc_v <= cb_v;
      cd_v <= cc_v;
    end
  end

  always_ff @(posedge clk) begin
    ca_m    <= e_sel[32] ? 33'(-e_sel) : 33'(e_sel);
    ca_w    <= w_sel;
    cb_hh   <= 34'(ca_m[32:16]) * 34'(ca_m[32:16]);
    cb_hl   <= 33'(ca_m[32:16]) * 33'(ca_m[15:0]);
    cb_ll   <= 32'(ca_m[15:0]) * 32'(ca_m[15:0]);
    cb_w    <= ca_w;
    cc_sq   <= sq_full[64:16];
    cc_w    <= cb_w;
    cd_term <= 57'(cc_w) * 57'(cc_sq);
  end

  // Running cost: saturate, clear at end of horizon
  always_ff @(posedge clk) begin
    if (rst) begin
      cost_acc <= '0;
    end else if (cmd.commit && item_last) begin
      cost_acc <= '0;
    end else if (cd_v) begin
      cost_acc <= acc_sum[48] ? COST_MAX : acc_sum[47:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      residual_x        <= at_start ? st_x : sat32(rx_full);
      residual_y        <= at_start ? st_y : sat32(ry_full);
      residual_heading  <= at_start ? st_h : sat32(rh_full);
      residual_speed    <= at_start ? st_v : sat32(rv_full);
      residual_yaw_rate <= at_start ? st_w : sat32(rw_full);
      cost_total        <= cost_acc;
      cost_final        <= item_last;
    end
  end

  assign status.last     = item_last;
  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/unicycle_mpc_residual_cost_unit.sv =====
// Unicycle MPC residual and cost unit: top level joining controller and datapath.
// Depends on umpc_pkg, umpc_ctrl and umpc_dp.
// Each transaction passes the states phase, remainder, CORDIC init, the 16-step CORDIC loop,
// quarter-turn fix, multiply and result (which waits for a free output register).
// The next transaction is taken while a finished result waits in the output register.
// Reset (rst, synchronous, active high) restores register defaults, clears the
// running cost and marks the next step as a horizon start.
module unicycle_mpc_residual_cost_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] heading,
  input  logic signed [31:0] speed,
  input  logic signed [31:0] yaw_rate,
  input  logic signed [31:0] accel,
  input  logic signed [31:0] yaw_accel,
  input  logic signed [31:0] ref_x,
  input  logic signed [31:0] ref_y,
  input  logic signed [31:0] ref_heading,
  input  logic signed [31:0] ref_speed,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] residual_x,
  output logic signed [31:0] residual_y,
  output logic signed [31:0] residual_heading,
  output logic signed [31:0] residual_speed,
  output logic signed [31:0] residual_yaw_rate,
  output logic [47:0]        cost_total,
  output logic               cost_final
);
  import umpc_pkg::*;

  umpc_cmd_t    cmd;
  umpc_status_t status;

  // Sequencer
  umpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic
  umpc_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .heading           (heading),
    .speed             (speed),
    .yaw_rate          (yaw_rate),
    .accel             (accel),
    .yaw_accel         (yaw_accel),
    .ref_x             (ref_x),
    .ref_y             (ref_y),
    .ref_heading       (ref_heading),
    .ref_speed         (ref_speed),
    .last              (last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .residual_x        (residual_x),
    .residual_y        (residual_y),
    .residual_heading  (residual_heading),
    .residual_speed    (residual_speed),
    .residual_yaw_rate (residual_yaw_rate),
    .cost_total        (cost_total),
    .cost_final        (cost_final)
  );

endmodule
